/* rtl/core/star_wildcard_matcher_top_defines.svh */
// ----------------------------------------------------------------------------
// Star wildcard matcher assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef STAR_WILDCARD_MATCHER_TOP_DEFINES_SVH
`define STAR_WILDCARD_MATCHER_TOP_DEFINES_SVH

// Same-cycle implication.
`define SWM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("swm assertion failed");

// Next-cycle implication.
`define SWM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("swm assertion failed");

`endif

/* rtl/core/swm_pkg.sv */
// ----------------------------------------------------------------------------
// swm_pkg
// Types, constants and helpers shared by the star wildcard matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

    localparam int PATTERN_MAX = 32;
    localparam int POS_N       = PATTERN_MAX + 1;
    localparam int POS_W       = $clog2(POS_N);
    localparam int LEN_W       = 6;
    localparam int IDX_W       = 5;
    localparam int BYTE_W      = 8;
    localparam int OP_W        = 2;
    localparam int CFG_IDX_W   = 1;

    localparam logic [BYTE_W-1:0] STAR_BYTE = 8'h2A;
    localparam logic [BYTE_W-1:0] UPPER_A   = 8'h41;
    localparam logic [BYTE_W-1:0] UPPER_Z   = 8'h5A;
    localparam logic [BYTE_W-1:0] CASE_OFS  = 8'h20;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_CASE    = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_PAT_WR = 2'd0,
        OP_TEXT   = 2'd1,
        OP_END    = 2'd2
    } t_op;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  idx;
        logic [BYTE_W-1:0] data;
    } t_pat_wr;

    typedef struct packed {
        logic text_en;
        logic end_en;
        logic last;
    } t_step_req;

    function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b,
                                                    input logic ic);
        if (ic && (b inside {[UPPER_A:UPPER_Z]})) begin
            return b + CASE_OFS;
        end
        return b;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/swm_pattern_store.sv */
// ----------------------------------------------------------------------------
// swm_pattern_store
// Pattern byte registers with per-position star flags and literal compares.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_pattern_store (
    input  wire logic                             i_clk,
    input  wire swm_pkg::t_pat_wr                 i_wr,
    input  wire logic                             i_ignore_case,
    input  wire logic [swm_pkg::BYTE_W-1:0]       i_text_byte,
    output logic      [swm_pkg::PATTERN_MAX-1:0]  o_star,
    output logic      [swm_pkg::PATTERN_MAX-1:0]  o_hit
);

    logic [swm_pkg::BYTE_W-1:0] r_store [swm_pkg::PATTERN_MAX];
    logic [swm_pkg::BYTE_W-1:0] text_fold;

    assign text_fold = swm_pkg::fold_byte(i_text_byte, i_ignore_case);

    // each entry decodes its own write; indexes past the store never match
    for (genvar e = 0; e < swm_pkg::PATTERN_MAX; e++) begin : g_entry
        always_ff @(posedge i_clk) begin
            if (i_wr.we && (32'(i_wr.idx) == e)) begin
                r_store[e] <= i_wr.data;
            end
        end

        assign o_star[e] = (r_store[e] == swm_pkg::STAR_BYTE);
        assign o_hit[e]  = (swm_pkg::fold_byte(r_store[e], i_ignore_case) == text_fold);
    end

endmodule

`default_nettype wire

/* rtl/core/swm_closure.sv */
// ----------------------------------------------------------------------------
// swm_closure
// Star closure of a reached-position set as a parallel-prefix network.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_closure (
    input  wire logic [swm_pkg::POS_N-1:0]       i_set,
    input  wire logic [swm_pkg::PATTERN_MAX-1:0] i_prop,
    output logic      [swm_pkg::POS_N-1:0]       o_set
);

    // c[i+1] = s[i+1] | (c[i] & prop[i]) is a carry chain; Kogge-Stone it
    logic [swm_pkg::POS_N-1:0] g;
    logic [swm_pkg::POS_N-1:0] p;
    logic [swm_pkg::POS_N-1:0] g_nx;
    logic [swm_pkg::POS_N-1:0] p_nx;

    always_comb begin
        g    = i_set;
        p    = {i_prop, 1'b0};
        g_nx = g;
        p_nx = p;
        for (int k = 0; k < swm_pkg::POS_W; k++) begin
            for (int i = 0; i < swm_pkg::POS_N; i++) begin
                if (i >= (1 << k)) begin
                    g_nx[i] = g[i] | (p[i] & g[i - (1 << k)]);
                    p_nx[i] = p[i] & p[i - (1 << k)];
                end else begin
                    g_nx[i] = g[i];
                    p_nx[i] = 1'b0;
                end
            end
            g = g_nx;
            p = p_nx;
        end
        o_set = g;
    end

endmodule

`default_nettype wire

/* rtl/core/swm_step.sv */
// ----------------------------------------------------------------------------
// swm_step
// Next reached-position set and match decision for one staged item.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_step (
    input  wire swm_pkg::t_step_req               i_req,
    input  wire logic [swm_pkg::POS_N-1:0]        i_reached,
    input  wire logic [swm_pkg::POS_W-1:0]        i_len,
    input  wire logic [swm_pkg::PATTERN_MAX-1:0]  i_star,
    input  wire logic [swm_pkg::PATTERN_MAX-1:0]  i_hit,
    output logic      [swm_pkg::POS_N-1:0]        o_reached,
    output logic                                  o_matched
);

    logic [swm_pkg::PATTERN_MAX-1:0] en;
    logic [swm_pkg::PATTERN_MAX-1:0] prop;
    logic [swm_pkg::PATTERN_MAX-1:0] stay;
    logic [swm_pkg::PATTERN_MAX-1:0] adv;
    logic [swm_pkg::POS_N-1:0]       cur;
    logic [swm_pkg::POS_N-1:0]       nxt;
    logic [swm_pkg::POS_N-1:0]       nxt_closed;

    always_comb begin
        for (int i = 0; i < swm_pkg::PATTERN_MAX; i++) begin
            en[i] = (32'(i) < 32'(i_len));
        end
    end

    assign prop = i_star & en;

    swm_closure u_close_cur (
        .i_set  (i_reached),
        .i_prop (prop),
        .o_set  (cur)
    );

    // a star keeps its position, a matching literal moves one on
    assign stay = cur[swm_pkg::PATTERN_MAX-1:0] & prop;
    assign adv  = cur[swm_pkg::PATTERN_MAX-1:0] & en & ~i_star & i_hit;
    assign nxt  = {1'b0, stay} | {adv, 1'b0};

    swm_closure u_close_nxt (
        .i_set  (nxt),
        .i_prop (prop),
        .o_set  (nxt_closed)
    );

    always_comb begin
        o_matched = i_req.text_en ? nxt_closed[i_len] : cur[i_len];
        if (i_req.text_en && !i_req.last) begin
            o_reached = nxt;
        end else if (i_req.text_en || i_req.end_en) begin
            o_reached = swm_pkg::POS_N'(1);
        end else begin
            o_reached = i_reached;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/star_wildcard_matcher_top.sv */
// ----------------------------------------------------------------------------
// star_wildcard_matcher_top
// Streaming '*'-only wildcard match of a text against a stored pattern.
// ----------------------------------------------------------------------------
// Takes one item per clock, except while a result item waits for the output
// register: a pattern byte write, a text byte, or an end of an empty text.
// An accepted item is held in the input register and is then applied
// combinationally to the reached-position vector; a result is loaded into the
// output register as its last text byte or end item leaves the input register.
// While a result waits on the output, items that give no result keep
// flowing; an item that gives a result waits in the input register until the
// output register frees. Pattern length saturates at PATTERN_MAX; ignore_case
// folds only A-Z. Configuration must be written only while the block is idle;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

`include "star_wildcard_matcher_top_defines.svh"

module star_wildcard_matcher_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration
    input  wire logic                              i_cfg_we,
    input  wire logic [swm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [swm_pkg::LEN_W-1:0]         i_cfg_data,
    // input channel
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [swm_pkg::OP_W-1:0]          i_operation,
    input  wire logic [swm_pkg::IDX_W-1:0]         i_pattern_index,
    input  wire logic [swm_pkg::BYTE_W-1:0]        i_data_byte,
    input  wire logic                              i_last_byte,
    // output channel
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic                                   o_matched
);

    logic                              r_in_valid;
    logic [swm_pkg::OP_W-1:0]          r_op;
    logic [swm_pkg::IDX_W-1:0]         r_idx;
    logic [swm_pkg::BYTE_W-1:0]        r_byte;
    logic                              r_last;

    logic [swm_pkg::POS_N-1:0]         r_reached;
    logic [swm_pkg::POS_N-1:0]         n_reached;
    logic [swm_pkg::POS_W-1:0]         r_len;
    logic [swm_pkg::POS_W-1:0]         n_len;
    logic                              r_ic;
    logic                              n_ic;

    logic                              r_out_valid;
    logic                              r_matched;
    logic                              n_matched;

    swm_pkg::t_step_req                req;
    swm_pkg::t_pat_wr                  pat_wr;
    logic [swm_pkg::PATTERN_MAX-1:0]   star;
    logic [swm_pkg::PATTERN_MAX-1:0]   hit;
    logic                              produce;
    logic                              out_free;
    logic                              advance;
    logic                              in_xfer;

    // staged item decode
    assign req.text_en = r_in_valid && (r_op == swm_pkg::OP_TEXT);
    assign req.end_en  = r_in_valid && (r_op == swm_pkg::OP_END);
    assign req.last    = r_last;

    assign produce  = req.end_en || (req.text_en && r_last);
    assign out_free = !r_out_valid || i_out_ready;
    assign advance  = r_in_valid && (!produce || out_free);

    assign o_in_ready = !r_in_valid || advance;
    assign in_xfer    = i_in_valid && o_in_ready;

    assign pat_wr.we   = advance && (r_op == swm_pkg::OP_PAT_WR);
    assign pat_wr.idx  = r_idx;
    assign pat_wr.data = r_byte;

    swm_pattern_store u_store (
        .i_clk         (i_clk),
        .i_wr          (pat_wr),
        .i_ignore_case (r_ic),
        .i_text_byte   (r_byte),
        .o_star        (star),
        .o_hit         (hit)
    );

    swm_step u_step (
        .i_req     (req),
        .i_reached (r_reached),
        .i_len     (r_len),
        .i_star    (star),
        .i_hit     (hit),
        .o_reached (n_reached),
        .o_matched (n_matched)
    );

    // configuration writes
    always_comb begin
        n_len = r_len;
        n_ic  = r_ic;
        if (i_cfg_we) begin
            case (i_cfg_index)
                swm_pkg::CFG_PATTERN_LENGTH: begin
                    if (32'(i_cfg_data) > swm_pkg::PATTERN_MAX) begin
                        n_len = swm_pkg::POS_W'(swm_pkg::PATTERN_MAX);
                    end else begin
                        n_len = swm_pkg::POS_W'(i_cfg_data);
                    end
                end
                swm_pkg::CFG_IGNORE_CASE: begin
                    n_ic = i_cfg_data[0];
                end
                default: begin
                    n_len = r_len;
                    n_ic  = r_ic;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_reached   <= swm_pkg::POS_N'(1);
            r_len       <= '0;
            r_ic        <= 1'b0;
        end else begin
            r_len <= n_len;
            r_ic  <= n_ic;
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_reached <= n_reached;
            end
            if (advance && produce) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op   <= i_operation;
            r_idx  <= i_pattern_index;
            r_byte <= i_data_byte;
            r_last <= i_last_byte;
        end
        if (advance && produce) begin
            r_matched <= n_matched;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_matched   = r_matched;

    `SWM_ASSERT_NEXT(a_result_loaded, advance && produce, r_out_valid)
    `SWM_ASSERT_NEXT(a_restart_after_result, advance && produce,
                     r_reached == swm_pkg::POS_N'(1))
    `SWM_ASSERT_NEXT(a_stage_holds, r_in_valid && !advance,
                     r_in_valid && $stable(r_byte) && $stable(r_op))
    `SWM_ASSERT_NOW(a_len_in_range, 1'b1, 32'(r_len) <= swm_pkg::PATTERN_MAX)

endmodule

`default_nettype wire
